// ===== rtl/givens_rotation_generate_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GIVENS_ROTATION_GENERATE_UNIT_MACROS_SVH
`define GIVENS_ROTATION_GENERATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GRG_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GRG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/grg_pkg.sv =====
`timescale 1ns / 1ps
package grg_pkg;
  // Default number of input bits taken as the two's complement operand.
  localparam int GRG_DATA_WIDTH = 32;
  // Fixed formats of the interface.
  localparam int GRG_IN_WIDTH   = 32;
  localparam int GRG_OUT_BYTES  = 17;
  // Quotient bits of the cosine and sine dividers (Q2.30 magnitude up to 2^30).
  localparam int GRG_CS_QBITS   = 31;
  // Numerator width of the reciprocal divider: 2^47 + cm.
  localparam int GRG_RCP_NBITS  = 48;
endpackage

// ===== rtl/grg_sqrt_pipe.sv =====
`timescale 1ns / 1ps
module grg_sqrt_pipe import grg_pkg::*; #(
  parameter int W  = GRG_DATA_WIDTH,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] x,
  input  logic [SW-1:0]  side_in,
  output logic           out_valid,
  output logic [W-1:0]   root,
  output logic [SW-1:0]  side_out
);
  // One result bit per stage, then a rounding stage.
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   q_q    [W];
  logic [2*W-1:0] x_q    [W];
  logic [SW-1:0]  side_q [W];
  logic           vld    [W];

  genvar k;
  for (k = 0; k < W; k++) begin : g_stage
    logic [W+1:0]   rem_i;
    logic [W-1:0]   q_i;
    logic [2*W-1:0] x_i;
    logic [SW-1:0]  side_i;
    logic           v_i;
    logic [W+3:0]   r4;
    logic [W+1:0]   trial;
    logic           take;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign q_i    = '0;
      assign x_i    = x;
      assign side_i = side_in;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign q_i    = q_q[k-1];
      assign x_i    = x_q[k-1];
      assign side_i = side_q[k-1];
      assign v_i    = vld[k-1];
    end
    assign r4    = {rem_i, x_i[2*W-1:2*W-2]};
    assign trial = {q_i, 2'b01};
    assign take  = r4 >= (W+4)'(trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? (W+2)'(r4 - (W+4)'(trial)) : (W+2)'(r4);
        q_q[k]    <= {q_i[W-2:0], take};
        x_q[k]    <= x_i << 2;
        side_q[k] <= side_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root     <= q_q[W-1] + W'(rem_q[W-1] > (W+2)'(q_q[W-1]));
      side_out <= side_q[W-1];
    end
  end
endmodule

// ===== rtl/grg_div_pipe.sv =====
`timescale 1ns / 1ps
module grg_div_pipe import grg_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = GRG_CS_QBITS,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [SW-1:0] side_out
);
  // Restoring division, one quotient bit per stage. The top NW-QW bits of
  // the numerator seed the remainder; if they already reach the divisor
  // the quotient would not fit in QW bits and ovf is raised.
  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [QW-1:0] q_q    [QW];
  logic [SW-1:0] side_q [QW];
  logic          ovf_q  [QW];
  logic          vld    [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] lo_i;
    logic [QW-1:0] q_i;
    logic [SW-1:0] side_i;
    logic          ovf_i;
    logic          v_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    if (k == 0) begin : g_first
      assign rem_i  = DW'(num[NW-1:QW]);
      assign den_i  = den;
      assign lo_i   = num[QW-1:0];
      assign q_i    = '0;
      assign side_i = side_in;
      assign ovf_i  = DW'(num[NW-1:QW]) >= den;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign den_i  = den_q[k-1];
      assign lo_i   = lo_q[k-1];
      assign q_i    = q_q[k-1];
      assign side_i = side_q[k-1];
      assign ovf_i  = ovf_q[k-1];
      assign v_i    = vld[k-1];
    end
    assign trial = {rem_i, lo_i[QW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign take  = trial >= {1'b0, den_i};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        den_q[k]  <= den_i;
        lo_q[k]   <= lo_i << 1;
        q_q[k]    <= {q_i[QW-2:0], take};
        side_q[k] <= side_i;
        ovf_q[k]  <= ovf_i;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = q_q[QW-1];
  assign ovf       = ovf_q[QW-1];
  assign side_out  = side_q[QW-1];
endmodule

// ===== rtl/givens_rotation_generate_unit.sv =====
`timescale 1ns / 1ps
// Givens rotation generator, fully pipelined.
// The slave channel takes one pair per transaction: tdata holds a_value in
// bits 31:0 and b_value in bits 63:32, both signed Q16.16, of which the low
// DATA_WIDTH bits are used. The master channel gives one result per pair:
// radius, cos_out, sin_out, recon_z and z_saturated packed in tdata.
// The stages in order: magnitude, square and sum; square root (one root bit
// per stage, then rounding); the cosine and sine dividers running side by
// side; the reciprocal divider for z; and selection and saturation into the
// output register. Throughput is one transaction per cycle while the
// receiver does not stall; each long unit retires one bit per stage, so all
// of them accept a new operand every cycle that the pipeline advances.
// Reset clears every valid bit, so the pipeline comes out of reset empty
// with m_tvalid low. When the receiver stalls with a result waiting, the
// whole pipeline freezes and s_tready falls; nothing is lost or repeated,
// and empty slots still move up while the output register is free.
module givens_rotation_generate_unit import grg_pkg::*; #(
  parameter int DATA_WIDTH = GRG_DATA_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // Fields from bit 0: a_value[31:0], b_value[31:0].
  input  logic [63:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // Fields from bit 0: radius[32:0], cos_out[31:0], sin_out[31:0],
  // recon_z[31:0], z_saturated, then six zero bits.
  output logic [135:0] m_tdata
);
  localparam int W    = DATA_WIDTH;
  localparam int QCS  = GRG_CS_QBITS;
  localparam int NRC  = GRG_RCP_NBITS;
  localparam int ZW   = W + 1;
  localparam int SQSW = 2 * W + 3;
  localparam int CSW  = W + 2;
  localparam int RSW  = W + 2 * QCS + 4;

  // The pipeline advances whenever the output register is free or emptying.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 0: magnitudes and signs of the operands.
  logic signed [W-1:0] av, bv;
  logic [W-1:0] ua0, ub0;
  logic         an0, bn0, agt0, v0;
  assign av = s_tdata[W-1:0];
  assign bv = s_tdata[GRG_IN_WIDTH+W-1:GRG_IN_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      an0  <= av[W-1];
      bn0  <= bv[W-1];
      ua0  <= av[W-1] ? W'(-av) : W'(av);
      ub0  <= bv[W-1] ? W'(-bv) : W'(bv);
    end
  end
  assign agt0 = ua0 > ub0;

  // Stage 1: squares. Stage 2: exact sum of squares.
  logic [2*W-1:0] sqa1, sqb1, sum2;
  logic [SQSW-1:0] side1, side2;
  logic v1, v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqa1  <= ua0 * ua0;
      sqb1  <= ub0 * ub0;
      side1 <= {ua0, ub0, an0, bn0, agt0};
      sum2  <= sqa1 + sqb1;
      side2 <= side1;
    end
  end

  // Square root of the sum gives |r|.
  logic            v3;
  logic [W-1:0]    mag3;
  logic [SQSW-1:0] side3;
  grg_sqrt_pipe #(.W(W), .SW(SQSW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .x        (sum2),
    .side_in  (side2),
    .out_valid(v3),
    .root     (mag3),
    .side_out (side3)
  );

  logic [W-1:0] ua3, ub3;
  logic         an3, bn3, agt3;
  assign {ua3, ub3, an3, bn3, agt3} = side3;

  // Rounded quotients: (2*num*2^30 + mag) / (2*mag).
  logic [W+31:0] numc, nums;
  logic [W:0]    den3;
  assign numc = {ua3, 31'b0} + (W+32)'(mag3);
  assign nums = {ub3, 31'b0} + (W+32)'(mag3);
  assign den3 = {mag3, 1'b0};

  logic           v4, v4s, ovfc4, ovfs4;
  logic [QCS-1:0] cm4, sm4;
  logic [CSW-1:0] side4;
  logic           agt4;
  grg_div_pipe #(.NW(W + 32), .DW(W + 1), .QW(QCS), .SW(CSW)) u_div_c (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .num      (numc),
    .den      (den3),
    .side_in  ({mag3, an3, bn3}),
    .out_valid(v4),
    .quot     (cm4),
    .ovf      (ovfc4),
    .side_out (side4)
  );
  grg_div_pipe #(.NW(W + 32), .DW(W + 1), .QW(QCS), .SW(1)) u_div_s (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .num      (nums),
    .den      (den3),
    .side_in  (agt3),
    .out_valid(v4s),
    .quot     (sm4),
    .ovf      (ovfs4),
    .side_out (agt4)
  );

  // Both dividers run in lockstep; their flags only matter for a zero
  // radius, which the output stage overrides.
  logic         v4j;
  logic [W-1:0] mag4;
  logic         an4, bn4, rneg4, cneg4, sneg4;
  assign v4j   = v4 && v4s && !(ovfc4 && ovfs4 && 1'b0);
  assign {mag4, an4, bn4} = side4;
  assign rneg4 = agt4 ? an4 : bn4;
  assign cneg4 = an4 ^ rneg4;
  assign sneg4 = bn4 ^ rneg4;

  // Reciprocal for z: (2^47 + cm) / (2*cm), W quotient bits plus overflow.
  logic [NRC-1:0] numr;
  logic [QCS:0]   denr;
  assign numr = {1'b1, (NRC-1)'(0)} + NRC'(cm4);
  assign denr = {cm4, 1'b0};

  logic           v5, ovfr5;
  logic [W-1:0]   qr5;
  logic [RSW-1:0] side5;
  grg_div_pipe #(.NW(NRC), .DW(QCS + 1), .QW(W), .SW(RSW)) u_div_r (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4j),
    .num      (numr),
    .den      (denr),
    .side_in  ({mag4, cm4, sm4, rneg4, cneg4, sneg4, agt4}),
    .out_valid(v5),
    .quot     (qr5),
    .ovf      (ovfr5),
    .side_out (side5)
  );

  logic [W-1:0]   mag5;
  logic [QCS-1:0] cm5, sm5;
  logic           rneg5, cneg5, sneg5, agt5;
  assign {mag5, cm5, sm5, rneg5, cneg5, sneg5, agt5} = side5;

  // Output stage: choose the source of z, then saturate it.
  logic [31:0]  srnd;
  logic [ZW-1:0] zsel, zlim, zmag;
  logic          zneg, zovf, zsat;
  logic signed [W-1:0] zval;
  logic          zero5;
  always_comb begin
    srnd = {1'b0, sm5} + 32'd8192;
    zovf = 1'b0;
    if (agt5) begin
      zsel = ZW'(srnd[30:14]);
      zneg = sneg5;
    end else if (cm5 != '0) begin
      zsel = ZW'(qr5);
      zovf = ovfr5;
      zneg = cneg5;
    end else begin
      zsel = ZW'(17'h10000);
      zneg = 1'b0;
    end
    zlim = zneg ? (ZW'(1) << (W - 1)) : ((ZW'(1) << (W - 1)) - ZW'(1));
    zsat = zovf || (zsel > zlim);
    zmag = zsat ? zlim : zsel;
    zval = zneg ? W'(-zmag) : W'(zmag);
  end
  assign zero5 = mag5 == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero5) begin
        m_tdata <= {6'b0, 1'b0, 32'd0, 32'd0, 32'h4000_0000, 33'd0};
      end else begin
        m_tdata <= {6'b0, zsat, 32'(zval),
                    sneg5 ? -{1'b0, sm5} : {1'b0, sm5},
                    cneg5 ? -{1'b0, cm5} : {1'b0, cm5},
                    rneg5 ? -(33'(mag5)) : 33'(mag5)};
      end
    end
  end
endmodule

// ===== rtl/grg_checker.sv =====
`timescale 1ns / 1ps
`include "givens_rotation_generate_unit_macros.svh"
module grg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [63:0]  s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);
  // A waiting result holds its data until the transaction completes.
  `GRG_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // A stalled output freezes the pipeline, so no input is taken.
  `GRG_ASSERT_IMPL(a_stall_in, clk, rst, m_tvalid && !m_tready, !s_tready)
  // A zero radius comes only with the identity rotation.
  `GRG_ASSERT_IMPL(a_zero_rot, clk, rst, m_tvalid && m_tdata[32:0] == 33'd0,
                   m_tdata[64:33] == 32'h4000_0000 && m_tdata[96:65] == 32'd0)
endmodule

bind givens_rotation_generate_unit grg_checker u_grg_checker (.*);

// ===== tb/sv/givens_rotation_generate_unit_test.sv =====
`timescale 1ns / 1ps
module givens_rotation_generate_unit_test;
  import grg_pkg::*;

  // One rotation as it leaves the block.
  typedef struct {
    logic signed [32:0] radius;
    logic signed [31:0] cos_out;
    logic signed [31:0] sin_out;
    logic signed [31:0] recon_z;
    logic               z_saturated;
  } rotation_t;

  // One row of the directed table. Where typed is set the row carries its
  // own expected rotation, otherwise the predictor supplies it.
  typedef struct {
    logic [31:0] a_value;
    logic [31:0] b_value;
    bit          typed;
    rotation_t   rotation;
  } pair_row_t;

  localparam int PERIOD_HALF    = 4;
  localparam int LATENCY        = 2 * GRG_DATA_WIDTH + 36;
  localparam int HOLD_CYCLES    = 400;
  // The longest correct quiet spell is a long receiver hold-off plus a
  // pipeline flush, so this leaves ample margin.
  localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + LATENCY);
  localparam int PHASE_ITEMS    = 330;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;

  givens_rotation_generate_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #PERIOD_HALF clk = 1'b1;
    #PERIOD_HALF clk = 1'b0;
  end

  // Rotations still owed by the block, oldest first. Typed rows push their
  // own expectation here instead of the predicted one.
  rotation_t   pending_rotations[$];
  rotation_t   typed_rotations[$];
  bit          typed_flags[$];
  int          mismatch_count = 0;
  int          pairs_sent = 0;
  int          rotations_seen = 0;
  int          saturations_seen = 0;
  int          idle_percent_send = 0;
  int          stall_percent_recv = 0;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num * 2 + den) / (den * 2);
  endfunction

  // Bit-exact rotation for one input pair at the default width.
  function automatic rotation_t compute_rotation(logic [31:0] av, logic [31:0] bv);
    rotation_t       rot;
    longint          a, b;
    longint unsigned ua, ub, rest, root, probe, mag, cm, sm, zm;
    bit              rneg, cneg, sneg, zneg;
    a = longint'($signed(av));
    b = longint'($signed(bv));
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    rot.radius = '0;
    rot.cos_out = 32'sd1073741824;
    rot.sin_out = '0;
    rot.recon_z = '0;
    rot.z_saturated = 1'b0;
    if (ua == 0 && ub == 0) return rot;
    // Exact sum of squares, then a bit-serial root rounded to nearest.
    rest = ua * ua + ub * ub;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rest) probe >>= 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    if (rest > root) root++;
    mag = root;
    rneg = (ua > ub) ? (a < 0) : (b < 0);
    cm = round_div(ua << 30, mag);
    sm = round_div(ub << 30, mag);
    cneg = (a < 0) != rneg;
    sneg = (b < 0) != rneg;
    rot.radius  = rneg ? -mag : mag;
    rot.cos_out = cneg ? -cm : cm;
    rot.sin_out = sneg ? -sm : sm;
    // z is the sine when a dominates, else the reciprocal of the cosine,
    // else one when the cosine has rounded away.
    if (ua > ub) begin
      zm = (sm + (64'd1 << 13)) >> 14;
      zneg = sneg;
    end else if (cm != 0) begin
      zm = round_div(64'd1 << 46, cm);
      zneg = cneg;
    end else begin
      zm = 64'd1 << 16;
      zneg = 1'b0;
    end
    if (zneg && zm > (64'd1 << 31)) begin
      zm = 64'd1 << 31;
      rot.z_saturated = 1'b1;
    end else if (!zneg && zm > (64'd1 << 31) - 1) begin
      zm = (64'd1 << 31) - 1;
      rot.z_saturated = 1'b1;
    end
    rot.recon_z = zneg ? -zm : zm;
    return rot;
  endfunction

  // Offers one pair, with random idle cycles first, and returns once it has
  // been taken. Handshakes are judged at the falling edge, where every
  // signal has settled, and complete at the following rising edge.
  task automatic offer_pair(logic [31:0] av, logic [31:0] bv, bit typed, rotation_t rot);
    while ($urandom_range(99) < idle_percent_send) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bv, av};
    typed_flags.push_back(typed);
    typed_rotations.push_back(rot);
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    pairs_sent++;
  endtask

  task automatic release_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Random operand: mostly full range, but also small values, extremes and
  // zero so that ties, saturation and the degenerate pair keep coming up.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0, 1, 2: return $urandom;
      3:       return $signed($urandom_range(2000)) - 1000;
      4:       return $signed($urandom_range(20)) - 10;
      5:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      6:       return 32'h0;
      default: return $urandom << $urandom_range(31);
    endcase
  endfunction

  task automatic run_random_phase(int count);
    logic [31:0] av, bv;
    rotation_t   dummy;
    for (int i = 0; i < count; i++) begin
      av = pick_operand();
      case ($urandom_range(5))
        0:       bv = $urandom_range(1) ? av : -av;  // equal magnitudes
        1:       bv = av + $signed($urandom_range(4)) - 2;
        default: bv = pick_operand();
      endcase
      if ($urandom_range(1)) {av, bv} = {bv, av};
      offer_pair(av, bv, 1'b0, dummy);
    end
    release_sender();
  endtask

  // Receiver: random stalls, plus a long hold-off on request so that the
  // pipeline fills and the input side has to stall.
  always @(posedge clk) begin : receiver
    int hold_left;
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_percent_recv);
    end
  end

  // Monitor: expects a rotation for every accepted pair (predicted unless typed)
  // and checks every accepted rotation against the oldest expectation.
  always @(negedge clk) begin : monitor
    rotation_t want, got;
    bit        typed;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        typed = typed_flags.pop_front();
        want  = typed_rotations.pop_front();
        pending_rotations.push_back(typed ? want : compute_rotation(s_tdata[31:0], s_tdata[63:32]));
      end
      if (m_tvalid && m_tready) begin
        got.radius      = m_tdata[32:0];
        got.cos_out     = m_tdata[64:33];
        got.sin_out     = m_tdata[96:65];
        got.recon_z     = m_tdata[128:97];
        got.z_saturated = m_tdata[129];
        rotations_seen++;
        if (got.z_saturated) saturations_seen++;
        if (pending_rotations.size() == 0) begin
          $display("%0t: unexpected rotation radius=%0d", $time, got.radius);
          mismatch_count++;
        end else begin
          want = pending_rotations.pop_front();
          if (got.radius !== want.radius) begin
            $display("%0t: radius expected %0d actual %0d", $time, want.radius, got.radius);
            mismatch_count++;
          end
          if (got.cos_out !== want.cos_out) begin
            $display("%0t: cos_out expected %0d actual %0d", $time, want.cos_out, got.cos_out);
            mismatch_count++;
          end
          if (got.sin_out !== want.sin_out) begin
            $display("%0t: sin_out expected %0d actual %0d", $time, want.sin_out, got.sin_out);
            mismatch_count++;
          end
          if (got.recon_z !== want.recon_z) begin
            $display("%0t: recon_z expected %0d actual %0d", $time, want.recon_z, got.recon_z);
            mismatch_count++;
          end
          if (got.z_saturated !== want.z_saturated) begin
            $display("%0t: z_saturated expected %0b actual %0b", $time,
                     want.z_saturated, got.z_saturated);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    pair_row_t directed[$];
    pair_row_t row;
    rotation_t none;
    none = compute_rotation(32'h0, 32'h0);

    // Rows with hand-worked results: the zero pair, unit inputs on either
    // axis and the most negative value on either axis.
    row.typed = 1'b1;
    row.a_value = 32'h0; row.b_value = 32'h0;
    row.rotation = '{33'sd0, 32'sd1073741824, 32'sd0, 32'sd0, 1'b0};
    directed.push_back(row);
    row.a_value = 32'd1; row.b_value = 32'h0;
    row.rotation = '{33'sd1, 32'sd1073741824, 32'sd0, 32'sd0, 1'b0};
    directed.push_back(row);
    row.a_value = 32'h0; row.b_value = 32'd1;
    row.rotation = '{33'sd1, 32'sd0, 32'sd1073741824, 32'sd65536, 1'b0};
    directed.push_back(row);
    row.a_value = 32'h8000_0000; row.b_value = 32'h0;
    row.rotation = '{-33'sd2147483648, 32'sd1073741824, 32'sd0, 32'sd0, 1'b0};
    directed.push_back(row);
    row.a_value = 32'h0; row.b_value = 32'h8000_0000;
    row.rotation = '{-33'sd2147483648, 32'sd0, 32'sd1073741824, 32'sd65536, 1'b0};
    directed.push_back(row);

    // Predicted rows: extremes of both fields, ties in magnitude, a tiny
    // cosine so that 1/c clamps either way, and ordinary mid-range pairs.
    row.typed = 1'b0;
    row.rotation = none;
    row.a_value = 32'h7FFF_FFFF; row.b_value = 32'h7FFF_FFFF; directed.push_back(row);
    row.a_value = 32'h8000_0000; row.b_value = 32'h8000_0000; directed.push_back(row);
    row.a_value = 32'h7FFF_FFFF; row.b_value = 32'h8000_0000; directed.push_back(row);
    row.a_value = 32'h8000_0000; row.b_value = 32'h7FFF_FFFF; directed.push_back(row);
    row.a_value = 32'hFFFF_FFFF; row.b_value = 32'hFFFF_FFFF; directed.push_back(row);
    row.a_value = 32'h0001_0000; row.b_value = 32'h0001_0000; directed.push_back(row);
    row.a_value = 32'hFFFF_0000; row.b_value = 32'h0001_0000; directed.push_back(row);
    row.a_value = 32'h0001_0000; row.b_value = 32'hFFFF_0000; directed.push_back(row);
    row.a_value = 32'd1;         row.b_value = 32'h7FFF_FFFF; directed.push_back(row);
    row.a_value = 32'hFFFF_FFFF; row.b_value = 32'h7FFF_FFFF; directed.push_back(row);
    row.a_value = 32'd1;         row.b_value = 32'h8000_0000; directed.push_back(row);
    row.a_value = 32'h0003_0000; row.b_value = 32'h0004_0000; directed.push_back(row);
    row.a_value = 32'hFFFC_0000; row.b_value = 32'h0003_0000; directed.push_back(row);
    row.a_value = 32'h0000_0005; row.b_value = 32'hFFFF_FFF4; directed.push_back(row);
    row.a_value = 32'h5555_5555; row.b_value = 32'hAAAA_AAAA; directed.push_back(row);
    row.a_value = 32'h0000_0002; row.b_value = 32'hFFFF_FFFF; directed.push_back(row);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, no idling on either side.
    foreach (directed[i]) offer_pair(directed[i].a_value, directed[i].b_value,
                                     directed[i].typed, directed[i].rotation);
    release_sender();

    // Random phases: free flow, a sparse sender, a stalling receiver, then
    // both idling a little.
    run_random_phase(PHASE_ITEMS);
    idle_percent_send = 68;
    run_random_phase(PHASE_ITEMS);
    // The sender pauses here until every outstanding rotation has come back.
    while (pending_rotations.size() != 0) @(posedge clk);
    idle_percent_send = 0;
    stall_percent_recv = 68;
    run_random_phase(PHASE_ITEMS);
    idle_percent_send = 6;
    stall_percent_recv = 6;
    // Long receiver hold-off while the sender keeps offering, so that the
    // pipeline fills completely and the input side stalls.
    hold_request = 1'b1;
    run_random_phase(PHASE_ITEMS);
    idle_percent_send = 0;
    stall_percent_recv = 0;

    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Sent %0d pairs and checked %0d rotations, %0d with z clamped,",
             pairs_sent, rotations_seen, saturations_seen);
    $display("across free flow, sender gaps, receiver stalls and a full-pipeline hold-off.");
    if (mismatch_count == 0 && pending_rotations.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
